// ===== hw/rtl/uwcr_pkg.sv =====
// Shared types and constants for the unaligned word copy realigner.
package uwcr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SOURCE_OFFSET = 2'd0;
  localparam logic [1:0] CFG_DEST_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_BYTE_COUNT    = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] source_word;
    logic        first_word;
  } uwcr_in_t;

  typedef struct packed {
    logic [31:0] dest_word;
    logic [3:0]  byte_enable;
    logic        last_write;
  } uwcr_out_t;

  // One classified source word: bytes already shifted down to lane 0
  typedef struct packed {
    logic [31:0] data;
    logic [3:0]  mask;
    logic [1:0]  lane;
    logic        restart;
    logic        is_last;
  } uwcr_op_t;

endpackage

// ===== hw/rtl/uwcr_front.sv =====
// Front end: accepts source words, tracks the byte count, classifies each word.
module uwcr_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  uwcr_pkg::uwcr_in_t    in_data,
  input  logic [1:0]            source_offset,
  input  logic [1:0]            dest_offset,
  input  logic [COUNT_BITS-1:0] byte_count,
  output logic                  push,
  output uwcr_pkg::uwcr_op_t    push_op,
  input  logic                  queue_full
);
  import uwcr_pkg::*;

  logic [COUNT_BITS-1:0] bytes_remaining;
  logic [1:0]            next_lane;
  logic                  transfer_active;

  logic                  accept;
  logic [COUNT_BITS-1:0] rem0;
  logic [1:0]            lane0;
  logic [1:0]            start;
  logic                  act0;
  logic [2:0]            avail;
  logic [2:0]            nbytes;
  logic [3:0]            kmask;
  logic [COUNT_BITS-1:0] rem_after;
  logic [31:0]           shifted;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_data.first_word) begin
      rem0  = byte_count;
      lane0 = dest_offset;
      start = source_offset;
      act0  = (byte_count != '0);
    end else begin
      rem0  = bytes_remaining;
      lane0 = next_lane;
      start = 2'd0;
      act0  = transfer_active;
    end
    avail     = 3'd4 - {1'b0, start};
    nbytes    = (rem0 < COUNT_BITS'(avail)) ? rem0[2:0] : avail;
    kmask     = 4'((5'd1 << nbytes) - 5'd1);
    rem_after = rem0 - COUNT_BITS'(nbytes);
    shifted   = in_data.source_word >> {start, 3'b000};
    push_op.data    = shifted & {{8{kmask[3]}}, {8{kmask[2]}}, {8{kmask[1]}}, {8{kmask[0]}}};
    push_op.mask    = kmask;
    push_op.lane    = lane0;
    push_op.restart = in_data.first_word;
    push_op.is_last = (rem_after == '0);
  end

  assign push = accept && act0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      next_lane       <= 2'd0;
      transfer_active <= 1'b0;
    end else if (accept) begin
      if (act0) begin
        bytes_remaining <= rem_after;
        next_lane       <= lane0 + nbytes[1:0];
        transfer_active <= (rem_after != '0);
      end else if (in_data.first_word) begin
        bytes_remaining <= '0;
        next_lane       <= dest_offset;
        transfer_active <= 1'b0;
      end
    end
  end

  a_active_has_bytes: assert property (@(posedge clk) disable iff (rst)
    transfer_active |-> (bytes_remaining != '0))
    else $error("active transfer with zero bytes remaining");

  a_push_has_bytes: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_op.mask != 4'd0))
    else $error("classified word carries no bytes");

endmodule

// ===== hw/rtl/uwcr_queue.sv =====
// Two-entry queue of classified words between front and back.
module uwcr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  uwcr_pkg::uwcr_op_t push_op,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output uwcr_pkg::uwcr_op_t q_op
);
  import uwcr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  uwcr_op_t              entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/uwcr_back.sv =====
// Back end: packs bytes into destination lanes and issues masked writes.
module uwcr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  uwcr_pkg::uwcr_op_t q_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output uwcr_pkg::uwcr_out_t out_data
);
  import uwcr_pkg::*;

  logic [31:0] pending_word;
  logic [3:0]  pending_mask;
  uwcr_out_t   extra;
  logic        extra_valid;

  logic        out_free;
  logic [63:0] word8;
  logic [7:0]  mask8;
  logic [31:0] base_word;
  logic [3:0]  base_mask;
  logic        wrap;
  logic        high_used;
  logic [1:0]  n_results;
  uwcr_out_t   r0;
  uwcr_out_t   r1;
  logic [31:0] pending_word_next;
  logic [3:0]  pending_mask_next;

  assign out_free = !out_valid || out_ready;
  assign pop      = q_valid && out_free && !extra_valid;

  always_comb begin
    base_word = q_op.restart ? 32'd0 : pending_word;
    base_mask = q_op.restart ? 4'd0  : pending_mask;
    word8 = {32'd0, base_word} | ({32'd0, q_op.data} << {q_op.lane, 3'b000});
    mask8 = {4'd0, base_mask} | ({4'd0, q_op.mask} << q_op.lane);
    wrap      = mask8[3];
    high_used = (mask8[7:4] != 4'd0);
    r0 = '{dest_word: word8[31:0], byte_enable: mask8[3:0], last_write: 1'b0};
    r1 = '{dest_word: word8[63:32], byte_enable: mask8[7:4], last_write: 1'b1};
    pending_word_next = word8[31:0];
    pending_mask_next = mask8[3:0];
    n_results = 2'd0;
    if (wrap) begin
      n_results         = 2'd1;
      r0.last_write     = q_op.is_last && !high_used;
      pending_word_next = word8[63:32];
      pending_mask_next = mask8[7:4];
      if (q_op.is_last && high_used) begin
        n_results = 2'd2;
      end
    end else if (q_op.is_last) begin
      n_results     = 2'd1;
      r0.last_write = 1'b1;
    end
    if (q_op.is_last) begin
      pending_word_next = 32'd0;
      pending_mask_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pending_word <= pending_word_next;
      pending_mask <= pending_mask_next;
    end
    if (extra_valid && out_free) begin
      out_data <= extra;
    end else if (pop && n_results != 2'd0) begin
      out_data <= r0;
    end
    if (pop && n_results == 2'd2) begin
      extra <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      extra_valid <= 1'b0;
    end else begin
      if (extra_valid && out_free) begin
        out_valid   <= 1'b1;
        extra_valid <= 1'b0;
      end else if (pop) begin
        out_valid   <= (n_results != 2'd0);
        extra_valid <= (n_results == 2'd2);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_extra_behind_out: assert property (@(posedge clk) disable iff (rst)
    extra_valid |-> out_valid)
    else $error("second write pending without a first write shown");

  a_no_pop_with_extra: assert property (@(posedge clk) disable iff (rst)
    extra_valid |-> !pop)
    else $error("queue popped while second write still pending");

endmodule

// ===== hw/rtl/unaligned_word_copy_realigner_top.sv =====
// Top level of the unaligned word copy realigner: config registers, front, queue, back.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data   (source_word, first_word)
//  out     | output    | out_valid / out_ready  | out_data  (dest_word, byte_enable, last_write)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One source word is taken per cycle while the queue is not full. A word that yields
// two writes (a wrap plus the tail) holds the back end while its second write is
// pending; under a steady input stream the queue then fills and in_ready drops.
// An input transfer reaches the output through the queue entry and then the output register.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// cfg_ready is always high; registers take effect at the next first word.
// A stalled output fills the queue, then drops in_ready.
module unaligned_word_copy_realigner_top #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  uwcr_pkg::uwcr_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output uwcr_pkg::uwcr_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data
);
  import uwcr_pkg::*;

  // Configuration registers
  logic [1:0]            source_offset;
  logic [1:0]            dest_offset;
  logic [COUNT_BITS-1:0] byte_count;

  // Front to queue, queue to back
  logic     push;
  uwcr_op_t push_op;
  logic     queue_full;
  logic     pop;
  logic     q_valid;
  uwcr_op_t q_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_offset <= 2'd0;
      dest_offset   <= 2'd0;
      byte_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOURCE_OFFSET: source_offset <= cfg_data[1:0];
        CFG_DEST_OFFSET:   dest_offset   <= cfg_data[1:0];
        CFG_BYTE_COUNT:    byte_count    <= cfg_data;
        default: ;  // index beyond the register list: write ignored
      endcase
    end
  end

  // Front: classifies words and tracks the remaining count
  uwcr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .source_offset (source_offset),
    .dest_offset   (dest_offset),
    .byte_count    (byte_count),
    .push          (push),
    .push_op       (push_op),
    .queue_full    (queue_full)
  );

  // Decoupling queue
  uwcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // Back: lane packing and masked write issue
  uwcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
